@@ src/ray_box_slab_intersect_unit_assert.svh @@
// ============================================================================
// Assertion macros for the ray versus box slab unit
// Shared wrappers for concurrent assertions clocked on the rising edge.
// ============================================================================
`ifndef RAY_BOX_SLAB_INTERSECT_UNIT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBSI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rbsi_pkg.sv @@
// ============================================================================
// Ray versus box slab unit package
// Widths, constants, types and the divider step shared by the unit.
// ============================================================================
package rbsi_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;

    localparam int DIFF_W = COORD_BITS + 3;        // bound minus origin, doubled units
    localparam int MAG_W  = COORD_BITS + 2;        // magnitude of that difference
    localparam int DVS_W  = COORD_BITS + 1;        // twice the direction magnitude
    localparam int QUO_W  = MAG_W + FRAC_BITS;     // dividend and quotient
    localparam int T_W    = 64;                    // slab distances
    localparam int CMP_W  = (QUO_W > T_W) ? QUO_W : T_W;
    localparam int DIST_W = COORD_BITS - 1;
    localparam int PROD_W = 2 * COORD_BITS - 1;
    localparam int SHF_W  = PROD_W - FRAC_BITS;
    localparam int MCMP_W = (SHF_W > T_W) ? SHF_W : T_W;
    localparam int SUM_W  = T_W + 1;

    localparam int IN_DW      = ((6 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_PAY_W  = DIST_W + 3 * COORD_BITS;
    localparam int OUT_DW     = ((OUT_PAY_W + 7) / 8) * 8;
    localparam int CFG_IW     = 3;

    localparam logic [T_W-1:0] T_CAP     = (T_W'(1) << 62) - T_W'(1);
    localparam logic [T_W-1:0] OFF_CAP   = T_W'(1) << 62;
    localparam logic [T_W-1:0] T_POS_INF = (T_W'(1) << (T_W - 1)) - T_W'(1);
    localparam logic [T_W-1:0] T_NEG_INF = T_W'(1) << (T_W - 1);
    localparam logic [T_W-1:0] DIST_MAX  = (T_W'(1) << DIST_W) - T_W'(1);
    localparam logic [SUM_W-1:0] SAT_HI  = (SUM_W'(1) << (COORD_BITS - 1)) - SUM_W'(1);
    localparam logic [SUM_W-1:0] SAT_LO  = ~SAT_HI;
    localparam logic [DIST_W-1:0] SIZE_RESET = DIST_W'(1) << FRAC_BITS;

    typedef enum logic [CFG_IW-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_SIZE_X   = 3'd3,
        CFG_SIZE_Y   = 3'd4,
        CFG_SIZE_Z   = 3'd5
    } cfg_idx_t;

    // One axis of the divider: both slab bounds share the divisor.
    typedef struct packed {
        logic [QUO_W-1:0] n_lo;
        logic [QUO_W-1:0] n_hi;
        logic [QUO_W-1:0] q_lo;
        logic [QUO_W-1:0] q_hi;
        logic [DVS_W-1:0] r_lo;
        logic [DVS_W-1:0] r_hi;
        logic [DVS_W-1:0] dvs;
    } div_axis_t;

    // Ray data that travels beside the divider.
    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] org;
        logic [2:0][COORD_BITS-1:0] dir;
        logic [2:0]                 neg_lo;
        logic [2:0]                 neg_hi;
        logic [2:0]                 lim;
        logic                       zmiss;
    } side_t;

    // One restoring step on both bounds of an axis.
    function automatic div_axis_t div_step(div_axis_t a);
        div_axis_t        b;
        logic [DVS_W:0]   tr_lo;
        logic [DVS_W:0]   tr_hi;
        logic             ge_lo;
        logic             ge_hi;
        b     = a;
        tr_lo = {a.r_lo, a.n_lo[QUO_W-1]};
        tr_hi = {a.r_hi, a.n_hi[QUO_W-1]};
        ge_lo = tr_lo >= {1'b0, a.dvs};
        ge_hi = tr_hi >= {1'b0, a.dvs};
        b.r_lo = ge_lo ? DVS_W'(tr_lo - {1'b0, a.dvs}) : DVS_W'(tr_lo);
        b.r_hi = ge_hi ? DVS_W'(tr_hi - {1'b0, a.dvs}) : DVS_W'(tr_hi);
        b.q_lo = {a.q_lo[QUO_W-2:0], ge_lo};
        b.q_hi = {a.q_hi[QUO_W-2:0], ge_hi};
        b.n_lo = a.n_lo << 1;
        b.n_hi = a.n_hi << 1;
        return b;
    endfunction

endpackage

@@ src/ray_box_slab_intersect_unit.sv @@
// The bit-per-stage slab divider makes up most of the pipeline (default 32-bit Q16.16).
// Throughput: one ray word per clock unless the result channel stalls, one result per ray.
// Reset (aresetn, synchronous, active low) empties the pipeline and the output
// register and restores the box to centre 0 and size 1.0 on every axis.
// ============================================================================
// Ray versus axis-aligned box intersection, slab method
// Streams rays through a deep pipeline and returns hit, distance and point.
// ============================================================================
module ray_box_slab_intersect_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from bit 0 upwards
    input  logic [rbsi_pkg::IN_DW-1:0]        s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit_distance, point_x, point_y, point_z from bit 0 upwards, zero padded
    output logic [rbsi_pkg::OUT_DW-1:0]       m_tdata,
    // hit
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbsi_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [rbsi_pkg::COORD_BITS-1:0]   cfg_data
);
    import rbsi_pkg::*;

    // ------------------------------------------------------------------
    // Box registers. Bounds are kept in doubled units so that halving the
    // size is exact: the slab runs from 2c - s to 2c + s.
    // ------------------------------------------------------------------
    logic [2:0][COORD_BITS-1:0] center_reg;
    logic [2:0][DIST_W-1:0]     size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                size_reg[i] <= SIZE_RESET;
            end
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: center_reg[0] <= cfg_data;
                CFG_CENTER_Y: center_reg[1] <= cfg_data;
                CFG_CENTER_Z: center_reg[2] <= cfg_data;
                CFG_SIZE_X:   size_reg[0]   <= cfg_data[DIST_W-1:0];
                CFG_SIZE_Y:   size_reg[1]   <= cfg_data[DIST_W-1:0];
                CFG_SIZE_Z:   size_reg[2]   <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The whole pipeline moves together; it may move when
    // the output register is free, is being emptied, or when the last
    // stage holds a bubble that would not be written into it anyway.
    // ------------------------------------------------------------------
    logic m_tvalid_reg;
    logic p3_v_reg;
    logic adv;
    logic out_load;

    assign out_load = !m_tvalid_reg || m_tready;
    assign adv      = out_load || !p3_v_reg;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Stage A: distances from the origin to both slab bounds.
    // ------------------------------------------------------------------
    logic                       a_v_reg;
    logic [2:0][DIFF_W-1:0]     a_dlo_reg;
    logic [2:0][DIFF_W-1:0]     a_dhi_reg;
    logic [2:0][COORD_BITS-1:0] a_org_reg;
    logic [2:0][COORD_BITS-1:0] a_dir_reg;
    logic [2:0][DIFF_W-1:0]     a_dlo_next;
    logic [2:0][DIFF_W-1:0]     a_dhi_next;

    always_comb begin
        logic [DIFF_W-1:0] c2;
        logic [DIFF_W-1:0] o2;
        logic [DIFF_W-1:0] sz;
        for (int i = 0; i < 3; i++) begin
            c2 = DIFF_W'($signed(center_reg[i])) << 1;
            o2 = DIFF_W'($signed(s_tdata[i*COORD_BITS +: COORD_BITS])) << 1;
            sz = DIFF_W'(size_reg[i]);
            a_dlo_next[i] = c2 - sz - o2;
            a_dhi_next[i] = c2 + sz - o2;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_dlo_reg <= a_dlo_next;
            a_dhi_reg <= a_dhi_next;
            for (int i = 0; i < 3; i++) begin
                a_org_reg[i] <= s_tdata[i*COORD_BITS +: COORD_BITS];
                a_dir_reg[i] <= s_tdata[(i+3)*COORD_BITS +: COORD_BITS];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: magnitudes and signs, loaded into the first divider slot.
    // A zero direction component sets no limit; the ray then misses when
    // the origin lies outside that slab.
    // ------------------------------------------------------------------
    div_axis_t div_reg  [0:QUO_W][3];
    side_t     side_reg [0:QUO_W];
    logic [QUO_W:0] div_v_reg;
    div_axis_t b_div_next [3];
    side_t     b_side_next;

    always_comb begin
        logic              sd;
        logic              slo;
        logic              shi;
        logic [DIFF_W-1:0] mlo;
        logic [DIFF_W-1:0] mhi;
        logic [COORD_BITS-1:0] dabs;
        b_side_next.org   = a_org_reg;
        b_side_next.dir   = a_dir_reg;
        b_side_next.zmiss = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sd   = a_dir_reg[i][COORD_BITS-1];
            slo  = a_dlo_reg[i][DIFF_W-1];
            shi  = a_dhi_reg[i][DIFF_W-1];
            mlo  = slo ? -a_dlo_reg[i] : a_dlo_reg[i];
            mhi  = shi ? -a_dhi_reg[i] : a_dhi_reg[i];
            dabs = sd ? -a_dir_reg[i] : a_dir_reg[i];
            b_side_next.neg_lo[i] = slo ^ sd;
            b_side_next.neg_hi[i] = shi ^ sd;
            b_side_next.lim[i]    = |a_dir_reg[i];
            // Origin inside the slab: lower bound at or below it, upper at or above.
            if (!(|a_dir_reg[i]) && !((slo || a_dlo_reg[i] == '0) && !shi)) begin
                b_side_next.zmiss = 1'b1;
            end
            b_div_next[i].n_lo = {mlo[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            b_div_next[i].n_hi = {mhi[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            b_div_next[i].q_lo = '0;
            b_div_next[i].q_hi = '0;
            b_div_next[i].r_lo = '0;
            b_div_next[i].r_hi = '0;
            b_div_next[i].dvs  = {dabs, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= b_side_next;
            for (int i = 0; i < 3; i++) begin
                div_reg[0][i] <= b_div_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage for all six bounds at once.
    // ------------------------------------------------------------------
    for (genvar k = 1; k <= QUO_W; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[k] <= side_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    div_reg[k][i] <= div_step(div_reg[k-1][i]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage T: clamp the quotients and give them their signs.
    // ------------------------------------------------------------------
    logic                  t_v_reg;
    side_t                 t_side_reg;
    logic [2:0][T_W-1:0]   t_lo_reg;
    logic [2:0][T_W-1:0]   t_hi_reg;
    logic [2:0][T_W-1:0]   t_lo_next;
    logic [2:0][T_W-1:0]   t_hi_next;

    always_comb begin
        logic [T_W-1:0] clo;
        logic [T_W-1:0] chi;
        for (int i = 0; i < 3; i++) begin
            clo = (CMP_W'(div_reg[QUO_W][i].q_lo) > CMP_W'(T_CAP)) ? T_CAP
                : T_W'(div_reg[QUO_W][i].q_lo);
            chi = (CMP_W'(div_reg[QUO_W][i].q_hi) > CMP_W'(T_CAP)) ? T_CAP
                : T_W'(div_reg[QUO_W][i].q_hi);
            t_lo_next[i] = side_reg[QUO_W].neg_lo[i] ? -clo : clo;
            t_hi_next[i] = side_reg[QUO_W].neg_hi[i] ? -chi : chi;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_side_reg <= side_reg[QUO_W];
            t_lo_reg   <= t_lo_next;
            t_hi_reg   <= t_hi_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: entry and exit distance per axis. Axes without a limit
    // are replaced by the infinities here.
    // ------------------------------------------------------------------
    logic                e_v_reg;
    side_t               e_side_reg;
    logic [2:0][T_W-1:0] e_te_reg;
    logic [2:0][T_W-1:0] e_tx_reg;
    logic [2:0][T_W-1:0] e_te_next;
    logic [2:0][T_W-1:0] e_tx_next;

    always_comb begin
        logic lt;
        for (int i = 0; i < 3; i++) begin
            lt = $signed(t_lo_reg[i]) < $signed(t_hi_reg[i]);
            e_te_next[i] = !t_side_reg.lim[i] ? T_NEG_INF : (lt ? t_lo_reg[i] : t_hi_reg[i]);
            e_tx_next[i] = !t_side_reg.lim[i] ? T_POS_INF : (lt ? t_hi_reg[i] : t_lo_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_side_reg <= t_side_reg;
            e_te_reg   <= e_te_next;
            e_tx_reg   <= e_tx_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages R1 and R2: tmin is the largest entry, tmax the smallest exit.
    // ------------------------------------------------------------------
    logic           r1_v_reg;
    side_t          r1_side_reg;
    logic [T_W-1:0] r1_tmin_reg;
    logic [T_W-1:0] r1_tmax_reg;
    logic [T_W-1:0] r1_te2_reg;
    logic [T_W-1:0] r1_tx2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_side_reg <= e_side_reg;
            r1_tmin_reg <= ($signed(e_te_reg[0]) > $signed(e_te_reg[1])) ? e_te_reg[0]
                         : e_te_reg[1];
            r1_tmax_reg <= ($signed(e_tx_reg[0]) < $signed(e_tx_reg[1])) ? e_tx_reg[0]
                         : e_tx_reg[1];
            r1_te2_reg  <= e_te_reg[2];
            r1_tx2_reg  <= e_tx_reg[2];
        end
    end

    logic           r2_v_reg;
    side_t          r2_side_reg;
    logic [T_W-1:0] r2_tmin_reg;
    logic [T_W-1:0] r2_tmax_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            r2_side_reg <= r1_side_reg;
            r2_tmin_reg <= ($signed(r1_te2_reg) > $signed(r1_tmin_reg)) ? r1_te2_reg
                         : r1_tmin_reg;
            r2_tmax_reg <= ($signed(r1_tx2_reg) < $signed(r1_tmax_reg)) ? r1_tx2_reg
                         : r1_tmax_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: hit decision and saturated hit distance.
    // ------------------------------------------------------------------
    logic              d_v_reg;
    side_t             d_side_reg;
    logic              d_miss_reg;
    logic [DIST_W-1:0] d_dist_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_side_reg <= r2_side_reg;
            d_miss_reg <= r2_side_reg.zmiss || r2_tmin_reg[T_W-1] || r2_tmax_reg[T_W-1]
                       || ($signed(r2_tmin_reg) > $signed(r2_tmax_reg));
            d_dist_reg <= ($signed(r2_tmin_reg) > $signed(DIST_MAX)) ? DIST_MAX[DIST_W-1:0]
                        : r2_tmin_reg[DIST_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stages P1 to P3: point = origin + direction * distance, saturated.
    // ------------------------------------------------------------------
    logic                   p1_v_reg;
    side_t                  p1_side_reg;
    logic                   p1_miss_reg;
    logic [DIST_W-1:0]      p1_dist_reg;
    logic [2:0][PROD_W-1:0] p1_prod_reg;

    always_ff @(posedge aclk) begin
        logic [COORD_BITS-1:0] dabs;
        if (adv) begin
            p1_side_reg <= d_side_reg;
            p1_miss_reg <= d_miss_reg;
            p1_dist_reg <= d_dist_reg;
            for (int i = 0; i < 3; i++) begin
                dabs = d_side_reg.dir[i][COORD_BITS-1] ? -d_side_reg.dir[i]
                     : d_side_reg.dir[i];
                p1_prod_reg[i] <= PROD_W'(dabs) * PROD_W'(d_dist_reg);
            end
        end
    end

    logic                p2_v_reg;
    side_t               p2_side_reg;
    logic                p2_miss_reg;
    logic [DIST_W-1:0]   p2_dist_reg;
    logic [2:0][T_W-1:0] p2_off_reg;

    always_ff @(posedge aclk) begin
        logic [SHF_W-1:0] m;
        logic [T_W-1:0]   mc;
        if (adv) begin
            p2_side_reg <= p1_side_reg;
            p2_miss_reg <= p1_miss_reg;
            p2_dist_reg <= p1_dist_reg;
            for (int i = 0; i < 3; i++) begin
                m  = p1_prod_reg[i][PROD_W-1:FRAC_BITS];
                mc = (MCMP_W'(m) > MCMP_W'(OFF_CAP)) ? OFF_CAP : T_W'(m);
                p2_off_reg[i] <= p1_side_reg.dir[i][COORD_BITS-1] ? -mc : mc;
            end
        end
    end

    logic                       p3_hit_reg;
    logic [DIST_W-1:0]          p3_dist_reg;
    logic [2:0][COORD_BITS-1:0] p3_pt_reg;

    always_ff @(posedge aclk) begin
        logic [SUM_W-1:0] s;
        if (adv) begin
            p3_hit_reg  <= !p2_miss_reg;
            p3_dist_reg <= p2_miss_reg ? '0 : p2_dist_reg;
            for (int i = 0; i < 3; i++) begin
                s = SUM_W'($signed(p2_side_reg.org[i])) + SUM_W'($signed(p2_off_reg[i]));
                if (p2_miss_reg) begin
                    p3_pt_reg[i] <= '0;
                end else if ($signed(s) > $signed(SAT_HI)) begin
                    p3_pt_reg[i] <= SAT_HI[COORD_BITS-1:0];
                end else if ($signed(s) < $signed(SAT_LO)) begin
                    p3_pt_reg[i] <= SAT_LO[COORD_BITS-1:0];
                end else begin
                    p3_pt_reg[i] <= s[COORD_BITS-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: parts the pipeline from the result channel.
    // ------------------------------------------------------------------
    logic                 hit_reg;
    logic [OUT_PAY_W-1:0] out_pay_reg;

    always_ff @(posedge aclk) begin
        if (out_load && p3_v_reg) begin
            hit_reg     <= p3_hit_reg;
            out_pay_reg <= {p3_pt_reg[2], p3_pt_reg[1], p3_pt_reg[0], p3_dist_reg};
        end
    end

    // Valid bits travel with the words; reset empties every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg      <= 1'b0;
            div_v_reg    <= '0;
            t_v_reg      <= 1'b0;
            e_v_reg      <= 1'b0;
            r1_v_reg     <= 1'b0;
            r2_v_reg     <= 1'b0;
            d_v_reg      <= 1'b0;
            p1_v_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            p3_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (adv) begin
                a_v_reg   <= s_tvalid;
                div_v_reg <= {div_v_reg[QUO_W-1:0], a_v_reg};
                t_v_reg   <= div_v_reg[QUO_W];
                e_v_reg   <= t_v_reg;
                r1_v_reg  <= e_v_reg;
                r2_v_reg  <= r1_v_reg;
                d_v_reg   <= r2_v_reg;
                p1_v_reg  <= d_v_reg;
                p2_v_reg  <= p1_v_reg;
                p3_v_reg  <= p2_v_reg;
            end
            if (out_load) begin
                m_tvalid_reg <= p3_v_reg;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser[0] = hit_reg;
    assign m_tdata    = OUT_DW'(out_pay_reg);

endmodule

@@ src/rbsi_checker.sv @@
// ============================================================================
// Port checker for the ray versus box slab unit
// Watches the streaming ports and the configuration port over time.
// ============================================================================
`include "ray_box_slab_intersect_unit_assert.svh"

module rbsi_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [rbsi_pkg::OUT_DW-1:0] m_tdata,
    input logic [0:0]                  m_tuser,
    input logic                        cfg_valid,
    input logic                        cfg_ready
);
    import rbsi_pkg::*;

    // A result word that is held back keeps its contents.
    `RBSI_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // A miss carries no distance and no point.
    `RBSI_ASSERT_NOW(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser[0],
        m_tdata == '0, "miss word carries non-zero payload")

    // The input side only waits when a finished result is held back.
    `RBSI_ASSERT_NOW(a_in_stall, aclk, aresetn, !s_tready,
        m_tvalid && !m_tready, "input stalled without a held result")

    // Configuration writes are always taken.
    `RBSI_ASSERT_NOW(a_cfg_ready, aclk, aresetn, cfg_valid,
        cfg_ready, "configuration write refused")

endmodule

bind ray_box_slab_intersect_unit rbsi_checker u_rbsi_checker (.*);
